// File: rtl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// shared types and constants for the signed integer to decimal text block
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int BITS_PER_STEP = 4;
    localparam int DIGIT_BITS    = 4;
    localparam int CHAR_BITS     = 6;

    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 6'd48;

    typedef struct packed {
        logic load;
        logic step;
        logic scan;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic emit_last;
    } t_dp_sts;

endpackage

// File: rtl/itoa_dp.sv
// ----------------------------------------------------------------------------
// itoa_dp
// datapath: magnitude, shift-add-3 bcd conversion, msd scan, character output
// ----------------------------------------------------------------------------
module itoa_dp #(
    parameter int VALUE_BITS = 32
) (
    input  logic                               i_clk,
    input  logic [VALUE_BITS-1:0]              i_value,
    input  itoa_pkg::t_dp_cmd                  i_cmd,
    output itoa_pkg::t_dp_sts                  o_sts,
    output logic [itoa_pkg::CHAR_BITS-1:0]     o_text_char,
    output logic                               o_last_char
);
    import itoa_pkg::*;

    localparam int STEPS = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int MAG_W = STEPS * BITS_PER_STEP;
    localparam int NDIG  = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_W = NDIG * DIGIT_BITS;
    localparam int IDX_W = $clog2(NDIG);

    logic [MAG_W-1:0]           r_mag;
    logic [BCD_W-1:0]           r_bcd;
    logic                       r_sign_pend;
    logic [IDX_W-1:0]           r_idx;
    logic [CHAR_BITS-1:0]       r_char;
    logic                       r_last;

    logic [VALUE_BITS-1:0]      abs_val;
    logic [MAG_W-1:0]           n_mag;
    logic [BCD_W-1:0]           n_bcd;
    logic [IDX_W-1:0]           msd_idx;
    logic [DIGIT_BITS-1:0]      cur_digit;

    assign abs_val = i_value[VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;

    // four shift-add-3 steps per cycle
    always_comb begin
        n_bcd = r_bcd;
        n_mag = r_mag;
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            for (int d = 0; d < NDIG; d++) begin
                if (n_bcd[d*DIGIT_BITS +: DIGIT_BITS] >= 4'd5) begin
                    n_bcd[d*DIGIT_BITS +: DIGIT_BITS] =
                        n_bcd[d*DIGIT_BITS +: DIGIT_BITS] + 4'd3;
                end
            end
            {n_bcd, n_mag} = {n_bcd[BCD_W-2:0], n_mag, 1'b0};
        end
    end

    // most significant nonzero digit, zero value gives index zero
    always_comb begin
        msd_idx = '0;
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[d*DIGIT_BITS +: DIGIT_BITS] != '0) begin
                msd_idx = IDX_W'(d);
            end
        end
    end

    assign cur_digit = r_bcd[r_idx*DIGIT_BITS +: DIGIT_BITS];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag       <= MAG_W'(abs_val);
            r_bcd       <= '0;
            r_sign_pend <= i_value[VALUE_BITS-1];
        end
        if (i_cmd.step) begin
            r_mag <= n_mag;
            r_bcd <= n_bcd;
        end
        if (i_cmd.scan) begin
            r_idx <= msd_idx;
        end
        if (i_cmd.emit) begin
            if (r_sign_pend) begin
                r_char      <= CHAR_MINUS;
                r_last      <= 1'b0;
                r_sign_pend <= 1'b0;
            end else begin
                r_char <= CHAR_ZERO + {2'b00, cur_digit};
                r_last <= (r_idx == '0);
                r_idx  <= r_idx - 1'b1;
            end
        end
    end

    assign o_sts.emit_last = !r_sign_pend && (r_idx == '0);
    assign o_text_char     = r_char;
    assign o_last_char     = r_last;

endmodule

// File: rtl/itoa_ctrl.sv
// ----------------------------------------------------------------------------
// itoa_ctrl
// controller: request handshakes, conversion step count, character sequencing
// ----------------------------------------------------------------------------
module itoa_ctrl #(
    parameter int STEPS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output itoa_pkg::t_dp_cmd o_cmd,
    input  itoa_pkg::t_dp_sts i_sts
);
    import itoa_pkg::*;

    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_out_valid;

    logic              in_fire;
    logic              out_fire;

    assign o_s_tready = (r_state == S_IDLE);
    assign in_fire    = i_s_tvalid && o_s_tready;
    assign out_fire   = r_out_valid && i_m_tready;
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        o_cmd.load = in_fire;
        o_cmd.step = (r_state == S_CONV);
        o_cmd.scan = (r_state == S_SCAN);
        o_cmd.emit = (r_state == S_EMIT) && (!r_out_valid || i_m_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_state <= S_CONV;
                        r_cnt   <= '0;
                    end
                end
                S_CONV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(STEPS - 1)) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (o_cmd.emit && i_sts.emit_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_accept_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_CONV))
        else $error("accepted request did not start conversion");

    a_emit_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (!r_out_valid || i_m_tready))
        else $error("character overwritten before it was taken");

    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> r_out_valid)
        else $error("emitted character not presented");

    a_last_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && i_sts.emit_last) |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after last character");
`endif

endmodule

// File: rtl/signed_int_to_decimal_ascii_top.sv
// conversion: after accept the value is converted four bits per cycle by
// shift-add-3 steps, the leading digit is scanned, then one character per
// cycle is emitted while the output is taken; the block takes a new request
// only after the last character of the previous one has been emitted
// reset: synchronous active low, clears controller state and output valid
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// signed integer to decimal ascii text, one character per output request
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top #(
    parameter int VALUE_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] i_s_axis_tdata,  // value
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [7:0]                            o_m_axis_tdata,  // text_char
    output logic                                  o_m_axis_tlast   // last_char
);
    import itoa_pkg::*;

    localparam int STEPS = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;

    t_dp_cmd              cmd;
    t_dp_sts              sts;
    logic [CHAR_BITS-1:0] text_char;

    itoa_ctrl #(
        .STEPS (STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    itoa_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_value     (i_s_axis_tdata[VALUE_BITS-1:0]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_text_char (text_char),
        .o_last_char (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {2'b00, text_char};

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// regression for the signed integer to decimal ascii converter: directed
// corner values, then random values under several idle and stall mixes and a
// long output hold-off; every character is checked against a local predictor
// ----------------------------------------------------------------------------
module tb;

    import itoa_pkg::*;

    localparam int VALUE_BITS  = 32;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last_char;
    } t_text_char;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [VALUE_BITS-1:0] i_s_axis_tdata  = '0;  // value
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [7:0]            o_m_axis_tdata;        // text_char
    logic                  o_m_axis_tlast;        // last_char

    t_text_char pending_chars[$];
    int         fail_count     = 0;
    int         cycle_count    = 0;
    int         hold_until     = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;

    signed_int_to_decimal_ascii_top #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("signed_int_to_decimal_ascii_top regression: fail");
            $finish;
        end
    end

    // output side: long hold-off window, else random stalls
    always @(posedge i_clk) begin
        if (cycle_count < hold_until) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // decimal text of one value, most significant character first
    function automatic void predict_text(input logic [VALUE_BITS-1:0] value);
        logic [VALUE_BITS-1:0] mag;
        logic [3:0]            digit_buf[12];
        int                    ndig;
        t_text_char            ch;
        ndig = 0;
        mag  = value[VALUE_BITS-1] ? ('0 - value) : value;
        do begin
            digit_buf[ndig] = 4'(mag % 10);
            mag = mag / 10;
            ndig++;
        end while (mag != 0);
        if (value[VALUE_BITS-1]) begin
            ch.text_char = {2'b00, CHAR_MINUS};
            ch.last_char = 1'b0;
            pending_chars.push_back(ch);
        end
        for (int i = ndig - 1; i >= 0; i--) begin
            ch.text_char = {2'b00, CHAR_ZERO + CHAR_BITS'(digit_buf[i])};
            ch.last_char = (i == 0);
            pending_chars.push_back(ch);
        end
    endfunction

    // random value: one in four fully random, else an even spread over digit counts and signs
    function automatic logic [VALUE_BITS-1:0] rand_value();
        int unsigned lo;
        int unsigned hi;
        int unsigned mag;
        int          ndig;
        logic        neg;
        neg = $urandom_range(1);
        if ($urandom_range(3) == 0) begin
            return $urandom();
        end
        ndig = $urandom_range(10, 1);
        lo = 1;
        for (int i = 1; i < ndig; i++) lo = lo * 10;
        if (ndig == 10) begin
            hi = neg ? 32'h8000_0000 : 32'h7fff_ffff;
        end else begin
            hi = lo * 10 - 1;
        end
        if (ndig == 1) lo = 0;
        mag = $urandom_range(hi, lo);
        return neg ? (32'd0 - mag) : mag;
    endfunction

    task automatic send_value(input logic [VALUE_BITS-1:0] value);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= $urandom();
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_text(value);
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected character: text_char actual %0d", o_m_axis_tdata);
                fail_count++;
            end else begin
                want = pending_chars.pop_front();
                if (o_m_axis_tdata !== want.text_char) begin
                    $error("text_char mismatch: expected %0d actual %0d",
                           want.text_char, o_m_axis_tdata);
                    fail_count++;
                end
                if (o_m_axis_tlast !== want.last_char) begin
                    $error("last_char mismatch: expected %0d actual %0d",
                           want.last_char, o_m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_corner_values();
        logic [VALUE_BITS-1:0] corners[20];
        corners = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                    32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                    -32'sd1000000000, 32'd999999999, 32'd123456789, -32'sd5,
                    32'haaaa_aaaa, 32'h5555_5555, -32'sd999999999, 32'd4294967295};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        foreach (corners[i]) send_value(corners[i]);
        wait_drained();
    endtask

    task automatic test_random_values(input int idle_pct, input int stall_pct,
                                      input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_value(rand_value());
        wait_drained();
    endtask

    task automatic test_output_hold_off();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_until     = cycle_count + 400;
        send_value(32'h8000_0000);
        repeat (11) send_value(32'h8000_0000 | $urandom());
        wait_drained();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corner_values();
        test_random_values(0, 0, 47);
        test_random_values(83, 0, 47);
        test_random_values(0, 83, 47);
        test_random_values(23, 23, 47);
        test_output_hold_off();
        test_random_values(0, 0, 10);
        if (fail_count == 0) begin
            $display("signed_int_to_decimal_ascii_top regression: pass");
        end else begin
            $display("signed_int_to_decimal_ascii_top regression: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/itoa_pkg.sv
rtl/itoa_dp.sv
rtl/itoa_ctrl.sv
rtl/signed_int_to_decimal_ascii_top.sv
tb/sv/tb.sv
